### rtl/core/smseq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smseq_pkg
// Shared types, command codes and coil tables of the stepper move sequencer.
// ----------------------------------------------------------------------------
package smseq_pkg;

	localparam logic [1:0] CMD_MOVE = 2'd0;
	localparam logic [1:0] CMD_TICK = 2'd1;
	localparam logic [1:0] CMD_STEP = 2'd2;

	// Reciprocal of 360 for the angle-to-steps conversion:
	// floor(x/360) == (x*RECIP_M) >> RECIP_S for every x below 381300.
	localparam int unsigned RECIP_M = 372828;
	localparam int unsigned RECIP_S = 27;

	localparam logic [8:0] STEPS_SAT = 9'd511;

	typedef struct packed {
		logic [3:0] coil_pattern;
		logic       stepped;
		logic       busy;
		logic       done;
		logic       rejected;
	} res_t;

	typedef struct packed {
		logic [2:0] idx;
		logic [3:0] coil;
	} phase_t;

	function automatic logic [3:0] full_coil(input logic [1:0] i);
		logic [3:0] c;
		case (i)
			2'd0: c = 4'h1;
			2'd1: c = 4'h2;
			2'd2: c = 4'h4;
			default: c = 4'h8;
		endcase
		return c;
	endfunction

	function automatic logic [3:0] half_coil(input logic [2:0] i);
		logic [3:0] c;
		case (i)
			3'd0: c = 4'h9;
			3'd1: c = 4'h1;
			3'd2: c = 4'h3;
			3'd3: c = 4'h2;
			3'd4: c = 4'h6;
			3'd5: c = 4'h4;
			3'd6: c = 4'hC;
			default: c = 4'h8;
		endcase
		return c;
	endfunction

endpackage

### rtl/core/smseq_phase.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smseq_phase
// Next phase index and coil pattern for one step in either mode.
// ----------------------------------------------------------------------------
module smseq_phase (
	input  logic [2:0]        idx,
	input  logic              dir,
	input  logic              half,
	output smseq_pkg::phase_t nxt
);
	import smseq_pkg::*;

	logic [2:0] idx_n;

	always_comb begin
		if (half) begin
			idx_n = dir ? (idx + 3'd1) : (idx - 3'd1);
			nxt.coil = half_coil(idx_n);
		end else begin
			// full mode: out-of-table indexes snap back into 0..3
			if (dir)
				idx_n = (idx >= 3'd3) ? 3'd0 : idx + 3'd1;
			else
				idx_n = (idx == 3'd0 || idx > 3'd4) ? 3'd3 : idx - 3'd1;
			nxt.coil = full_coil(idx_n[1:0]);
		end
		nxt.idx = idx_n;
	end

endmodule

### rtl/core/smseq_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smseq_ctrl
// Input register, move/step/tick state and per-item result.
// ----------------------------------------------------------------------------
module smseq_ctrl #(
	parameter int STEPS_PER_REV = 200
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [1:0]        cmd,
	input  logic              direction,
	input  logic              half_mode,
	input  logic [7:0]        degrees,
	input  logic [7:0]        delay_ms,
	input  logic              push_ok,
	output logic              push,
	output smseq_pkg::res_t   res
);
	import smseq_pkg::*;

	localparam logic [31:0] K_FULL = 32'(STEPS_PER_REV * RECIP_M);
	localparam logic [31:0] K_HALF = 32'(2 * STEPS_PER_REV * RECIP_M);

	// input stage
	logic       valid_s1;
	logic [1:0] cmd_s1;
	logic       dir_s1, half_s1;
	logic [7:0] deg_s1, dly_s1;

	// block state
	logic [2:0] phase_q;
	logic [3:0] coil_q;
	logic [8:0] steps_q;
	logic [7:0] wait_q;
	logic       active_q;
	logic       sdir_q, shalf_q;
	logic [7:0] sdly_q;

	logic       take;
	logic [39:0] prod;
	logic [12:0] total;
	logic [8:0]  steps_init;

	logic        st_dir, st_half, do_step;
	phase_t      nxt;

	logic [2:0] phase_d;
	logic [3:0] coil_d;
	logic [8:0] steps_d;
	logic [7:0] wait_d;
	logic       active_d, sdir_d, shalf_d;
	logic [7:0] sdly_d;
	logic       stepped_d, done_d, rej_d;

	assign push     = valid_s1 && push_ok;
	assign in_ready = !valid_s1 || push_ok;
	assign take     = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (in_ready)
			valid_s1 <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (take) begin
			cmd_s1  <= cmd;
			dir_s1  <= direction;
			half_s1 <= half_mode;
			deg_s1  <= degrees;
			dly_s1  <= delay_ms;
		end
	end

	// steps = floor(deg * steps_per_rev * (1|2) / 360)
	assign prod  = {32'd0, deg_s1} * {8'd0, (half_s1 ? K_HALF : K_FULL)};
	assign total = prod[RECIP_S +: 13];
	assign steps_init = (total > 13'd512) ? STEPS_SAT : 9'(total - 13'd1);

	assign st_dir  = (cmd_s1 == CMD_TICK) ? sdir_q  : dir_s1;
	assign st_half = (cmd_s1 == CMD_TICK) ? shalf_q : half_s1;

	smseq_phase u_phase (
		.idx  (phase_q),
		.dir  (st_dir),
		.half (st_half),
		.nxt  (nxt)
	);

	always_comb begin
		steps_d   = steps_q;
		wait_d    = wait_q;
		active_d  = active_q;
		sdir_d    = sdir_q;
		shalf_d   = shalf_q;
		sdly_d    = sdly_q;
		do_step   = 1'b0;
		done_d    = 1'b0;
		rej_d     = 1'b0;
		case (cmd_s1)
			CMD_MOVE: begin
				if (active_q) begin
					rej_d = 1'b1;
				end else if (total == 13'd0) begin
					done_d = 1'b1;
				end else begin
					sdir_d   = dir_s1;
					shalf_d  = half_s1;
					sdly_d   = dly_s1;
					do_step  = 1'b1;
					steps_d  = steps_init;
					wait_d   = dly_s1;
					active_d = 1'b1;
				end
			end
			CMD_TICK: begin
				if (active_q) begin
					if (wait_q > 8'd1) begin
						wait_d = wait_q - 8'd1;
					end else if (steps_q != 9'd0) begin
						do_step = 1'b1;
						steps_d = steps_q - 9'd1;
						wait_d  = sdly_q;
					end else begin
						wait_d   = 8'd0;
						active_d = 1'b0;
						done_d   = 1'b1;
					end
				end
			end
			CMD_STEP: begin
				if (active_q)
					rej_d = 1'b1;
				else
					do_step = 1'b1;
			end
			default: ;
		endcase
		phase_d   = do_step ? nxt.idx  : phase_q;
		coil_d    = do_step ? nxt.coil : coil_q;
		stepped_d = do_step;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= 3'd0;
			coil_q   <= 4'd0;
			steps_q  <= 9'd0;
			wait_q   <= 8'd0;
			active_q <= 1'b0;
			sdir_q   <= 1'b0;
			shalf_q  <= 1'b0;
			sdly_q   <= 8'd0;
		end else if (push) begin
			phase_q  <= phase_d;
			coil_q   <= coil_d;
			steps_q  <= steps_d;
			wait_q   <= wait_d;
			active_q <= active_d;
			sdir_q   <= sdir_d;
			shalf_q  <= shalf_d;
			sdly_q   <= sdly_d;
		end
	end

	assign res.coil_pattern = coil_d;
	assign res.stepped      = stepped_d;
	assign res.busy         = active_d;
	assign res.done         = done_d;
	assign res.rejected     = rej_d;

endmodule

### rtl/core/smseq_outbuf.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smseq_outbuf
// Result register with one skid entry behind it.
// ----------------------------------------------------------------------------
module smseq_outbuf (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  smseq_pkg::res_t res_in,
	output logic            push_ok,
	output logic            out_valid,
	input  logic            out_ready,
	output smseq_pkg::res_t res_out
);
	import smseq_pkg::*;

	logic out_valid_q, skid_valid_q;
	res_t out_q, skid_q;
	logic pop;

	assign pop       = out_valid_q && out_ready;
	assign push_ok   = !skid_valid_q;
	assign out_valid = out_valid_q;
	assign res_out   = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (!out_valid_q || pop) begin
			if (skid_valid_q) begin
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= push;
			end
		end else if (push) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_valid_q || pop) begin
			if (skid_valid_q)
				out_q <= skid_q;
			else if (push)
				out_q <= res_in;
		end else if (push) begin
			skid_q <= res_in;
		end
	end

endmodule

### rtl/core/stepper_move_sequencer_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stepper_move_sequencer_core
// Four-coil stepper sequencer: single steps, timed moves, full/half step.
// ----------------------------------------------------------------------------
//
//  channel | handshake            | payload
//  --------+----------------------+---------------------------------------------
//  input   | in_valid / in_ready  | cmd, direction, half_mode, degrees, delay_ms
//  output  | out_valid/ out_ready | coil_pattern, stepped, busy_res, move_done,
//          |                      | rejected
//
//  One transaction in, one transaction out. Throughput is one item per cycle
//  while out_ready stays high. Each item passes the input register, then the
//  state update that loads the result register. That update, including the
//  degrees-to-steps multiply by a reciprocal of 360, is one pass between them.
//  Reset (arst_n low) clears phase, coils, move counters and all valid flags.
//  When out_ready stalls, the skid entry keeps in_ready high for one more
//  transaction; after that the input side holds until the result is taken.
//
module stepper_move_sequencer_core #(
	parameter int STEPS_PER_REV = 200
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [1:0] cmd,
	input  logic       direction,
	input  logic       half_mode,
	input  logic [7:0] degrees,
	input  logic [7:0] delay_ms,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [3:0] coil_pattern,
	output logic       stepped,
	output logic       busy_res,
	output logic       move_done,
	output logic       rejected
);
	import smseq_pkg::*;

	logic push, push_ok;
	res_t res_new, res_cur;

	// command decode, state registers and the per-item result
	smseq_ctrl #(
		.STEPS_PER_REV (STEPS_PER_REV)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.cmd       (cmd),
		.direction (direction),
		.half_mode (half_mode),
		.degrees   (degrees),
		.delay_ms  (delay_ms),
		.push_ok   (push_ok),
		.push      (push),
		.res       (res_new)
	);

	// result register plus skid so a stalled consumer does not stop intake at once
	smseq_outbuf u_outbuf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.res_in    (res_new),
		.push_ok   (push_ok),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.res_out   (res_cur)
	);

	assign coil_pattern = res_cur.coil_pattern;
	assign stepped      = res_cur.stepped;
	assign busy_res     = res_cur.busy;
	assign move_done    = res_cur.done;
	assign rejected     = res_cur.rejected;

endmodule
